### hdl/hcbp_pkg.sv
`timescale 1ns / 1ps

package hcbp_pkg;

    // Field widths of the stream items.
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 24;
    localparam int LEN_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 24;
    localparam int GBITS_W = 4;
    localparam int OP_W    = 2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Longest code that a table entry may hold.
    localparam int MAX_CODE_LEN = 24;

    localparam int ENTRY_W = CODE_W + LEN_W;
    localparam int BUF_W   = 7;
    localparam int FILL_W  = 3;
    localparam int ACC_W   = BUF_W + MAX_CODE_LEN;
    localparam int TOT_W   = $clog2(ACC_W + 1);
    localparam int MAX_RES = ACC_W / 8;
    localparam int NRES_W  = $clog2(MAX_RES + 1);

    localparam int DEF_SYMBOLS    = 256;
    localparam int DEF_COUNT_BITS = 24;

    localparam logic [BYTE_W-1:0] ESCAPE_GROUP = 8'b0001_1010;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_ESCAPE  = 2'd1,
        KIND_TRAILER = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   byte_value;
        logic [POS_W-1:0]    position;
        logic [GBITS_W-1:0]  group_bits;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              escaped;
        logic              count_zero;
    } pack_status_t;

    // Table entry as stored: length saturated, code bits above the length cleared.
    function automatic logic [ENTRY_W-1:0] make_entry(input logic [CODE_W-1:0] code,
                                                      input logic [LEN_W-1:0]  len);
        logic [LEN_W-1:0]  sat_len;
        logic [CODE_W-1:0] keep;
        sat_len = (len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : len;
        keep    = ~({CODE_W{1'b1}} << sat_len);
        return {code & keep, sat_len};
    endfunction

endpackage

### hdl/hcbp_ram.sv
`timescale 1ns / 1ps

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/hcbp_pack.sv
`timescale 1ns / 1ps

module hcbp_pack #(
    parameter int COUNT_BITS = hcbp_pkg::DEF_COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          is_flush,
    input  logic                          hit,
    input  logic [hcbp_pkg::ENTRY_W-1:0]  entry,
    output hcbp_pkg::result_t             res [hcbp_pkg::MAX_RES],
    output logic [hcbp_pkg::NRES_W-1:0]   n_res,
    output hcbp_pkg::pack_status_t        status
);

    import hcbp_pkg::*;

    logic [BUF_W-1:0]      buf_reg, buf_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  esc_reg, esc_next;

    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  aligned;
    logic [TOT_W-1:0]  total;
    logic [NRES_W-1:0] ngroups;

    // Entries of symbols outside the table append nothing.
    assign len     = hit ? entry[LEN_W-1:0] : '0;
    assign code    = hit ? entry[ENTRY_W-1:LEN_W] : '0;
    assign acc     = (ACC_W'(buf_reg) << len) | ACC_W'(code);
    assign total   = TOT_W'(fill_reg) + TOT_W'(len);
    // Oldest pending bit moves to the top, so groups read out at fixed places.
    assign aligned = acc << (TOT_W'(ACC_W) - total);
    assign ngroups = NRES_W'(total >> 3);

    always_comb
    begin
        logic [COUNT_BITS-1:0] cnt;
        logic                  esc;
        logic [BYTE_W-1:0]     grp;
        cnt = count_reg;
        esc = esc_reg;
        grp = '0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            res[k] = result_t'('0);
        end
        n_res      = '0;
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        esc_next   = esc_reg;

        if (is_flush)
        begin
            if (fill_reg != '0)
            begin
                res[0].kind       = KIND_DATA;
                res[0].byte_value = BYTE_W'(buf_reg);
                res[0].position   = POS_W'(count_reg);
                res[0].group_bits = GBITS_W'(fill_reg);
                res[1].kind       = KIND_TRAILER;
                res[1].position   = POS_W'(count_reg + COUNT_BITS'(1));
                res[1].group_bits = GBITS_W'(fill_reg);
                res[1].last       = 1'b1;
                n_res             = NRES_W'(2);
            end
            else
            begin
                // A trailer after an escape, or with no data byte counted, reports zero.
                res[0].kind       = KIND_TRAILER;
                res[0].position   = POS_W'(count_reg);
                res[0].group_bits = (esc_reg || count_reg == '0) ? '0 : GBITS_W'(8);
                res[0].last       = 1'b1;
                n_res             = NRES_W'(1);
            end
            buf_next   = '0;
            fill_next  = '0;
            count_next = '0;
            esc_next   = 1'b0;
        end
        else
        begin
            for (int k = 0; k < MAX_RES; k++)
            begin
                grp = aligned[ACC_W-1-8*k -: BYTE_W];
                if (NRES_W'(k) < ngroups)
                begin
                    esc               = (grp == ESCAPE_GROUP);
                    res[k].kind       = esc ? KIND_ESCAPE : KIND_DATA;
                    res[k].byte_value = esc ? '0 : grp;
                    res[k].position   = POS_W'(cnt);
                    res[k].group_bits = GBITS_W'(8);
                    res[k].last       = (NRES_W'(k + 1) == ngroups);
                    if (!esc)
                    begin
                        cnt = cnt + COUNT_BITS'(1);
                    end
                end
            end
            n_res      = ngroups;
            count_next = cnt;
            esc_next   = esc;
            buf_next   = BUF_W'(acc) & ~({BUF_W{1'b1}} << total[FILL_W-1:0]);
            fill_next  = total[FILL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
            esc_reg   <= 1'b0;
        end
        else if (step)
        begin
            buf_reg   <= buf_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            esc_reg   <= esc_next;
        end
    end

    assign status.fill       = fill_reg;
    assign status.escaped    = esc_reg;
    assign status.count_zero = (count_reg == '0);

endmodule

### hdl/hcbp_outbuf.sv
`timescale 1ns / 1ps

module hcbp_outbuf (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  hcbp_pkg::result_t            res [hcbp_pkg::MAX_RES],
    input  logic [hcbp_pkg::NRES_W-1:0]  n_res,
    input  logic                         ready,
    output logic                         valid,
    output hcbp_pkg::result_t            head,
    output logic                         free,
    output logic [hcbp_pkg::NRES_W-1:0]  count
);

    import hcbp_pkg::*;

    result_t           ent_reg [MAX_RES];
    logic [NRES_W-1:0] count_reg;
    logic              pop;

    assign valid = (count_reg != '0);
    assign pop   = valid && ready;
    // A new burst may land when the buffer is empty or its final result leaves now.
    assign free  = (count_reg == '0) || (count_reg == NRES_W'(1) && ready);
    assign head  = ent_reg[0];
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (load)
        begin
            count_reg <= n_res;
        end
        else if (pop)
        begin
            count_reg <= count_reg - NRES_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < MAX_RES; k++)
            begin
                ent_reg[k] <= res[k];
            end
        end
        else if (pop)
        begin
            for (int k = 0; k < MAX_RES - 1; k++)
            begin
                ent_reg[k] <= ent_reg[k + 1];
            end
        end
    end

endmodule

### hdl/huffman_code_bit_packer_top.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                           tuser      tlast
// s_axis    in         symbol, code_word, code_length, zero pad      opcode     -
// m_axis    out        byte_value, position, group_bits, zero pad    kind       last
//
// A request is accepted every cycle while the output buffer can take each burst; a load ends at the table write.
// Results leave one per cycle while m_axis_tready is high; a burst holds the output.
// A request's table read is registered, then its results are packed into the output buffer.
// Reset clears the stream state; the code table is not cleared and must be loaded first.
// A stalled output holds the pending request in the table-read stage and drops s_axis_tready.

module huffman_code_bit_packer_top #(
    parameter int SYMBOLS    = hcbp_pkg::DEF_SYMBOLS,
    parameter int COUNT_BITS = hcbp_pkg::DEF_COUNT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // symbol [7:0], code_word [31:8], code_length [36:32], zero [39:37]
    input  logic [hcbp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode [1:0]
    input  logic [hcbp_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // byte_value [7:0], position [31:8], group_bits [35:32], zero [39:36]
    output logic [hcbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // kind [1:0]
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    import hcbp_pkg::*;

    localparam int AW = $clog2(SYMBOLS);

    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic              s_accept;
    logic              in_hit;
    logic              is_load, is_encode, is_flush;

    logic              valid_a_reg, valid_a_next;
    logic              flush_a_reg;
    logic              hit_a_reg;
    logic              advance;

    logic [ENTRY_W-1:0] entry;
    result_t            res [MAX_RES];
    logic [NRES_W-1:0]  n_res;
    pack_status_t       status;

    result_t           head;
    logic              buf_free;
    logic [NRES_W-1:0] out_count;

    assign symbol      = s_axis_tdata[SYM_W-1:0];
    assign code_word   = s_axis_tdata[SYM_W+CODE_W-1:SYM_W];
    assign code_length = s_axis_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W];

    assign is_load   = (s_axis_tuser == OP_LOAD);
    assign is_encode = (s_axis_tuser == OP_ENCODE);
    assign is_flush  = (s_axis_tuser == OP_FLUSH);
    assign in_hit    = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOLS));

    assign advance       = valid_a_reg && buf_free;
    assign s_axis_tready = !valid_a_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOLS)
    ) u_table (
        .clk   (clk),
        .we    (s_accept && is_load && in_hit),
        .waddr (symbol[AW-1:0]),
        .wdata (make_entry(code_word, code_length)),
        .re    (s_accept && is_encode),
        .raddr (symbol[AW-1:0]),
        .rdata (entry)
    );

    // Loads finish at the table write; only encodes and flushes occupy the read stage.
    always_comb
    begin
        valid_a_next = valid_a_reg;
        if (s_accept && (is_encode || is_flush))
        begin
            valid_a_next = 1'b1;
        end
        else if (advance)
        begin
            valid_a_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= valid_a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            flush_a_reg <= is_flush;
            hit_a_reg   <= in_hit;
        end
    end

    hcbp_pack #(
        .COUNT_BITS (COUNT_BITS)
    ) u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .is_flush (flush_a_reg),
        .hit      (hit_a_reg),
        .entry    (entry),
        .res      (res),
        .n_res    (n_res),
        .status   (status)
    );

    hcbp_outbuf u_outbuf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance),
        .res   (res),
        .n_res (n_res),
        .ready (m_axis_tready),
        .valid (m_axis_tvalid),
        .head  (head),
        .free  (buf_free),
        .count (out_count)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - BYTE_W - POS_W - GBITS_W)'(0),
                           head.group_bits, head.position, head.byte_value};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    // A flush returns the stream state to its start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && flush_a_reg) |=>
        (status.fill == '0 && !status.escaped && status.count_zero))
        else $error("stream state not cleared after flush");

    // Every flush yields at least the trailer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && flush_a_reg) |=> m_axis_tvalid)
        else $error("flush produced no trailer");

    // The last flag marks exactly the final buffered result of a burst.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_count == NRES_W'(1)) |-> m_axis_tlast)
        else $error("final result of a burst lacks last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_count > NRES_W'(1)) |-> !m_axis_tlast)
        else $error("last set before the end of a burst");

endmodule

### sim/huffman_code_bit_packer_top_tb.sv
`timescale 1ns / 1ps

module huffman_code_bit_packer_top_tb;

    import hcbp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = OP_LOAD;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    huffman_code_bit_packer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    // Shadow copy of the code table and the stream state.
    logic [CODE_W-1:0]  lut_code    [256];
    logic [LEN_W-1:0]   lut_len     [256];
    bit                 lut_written [256];
    logic [SYM_W-1:0]   loaded_symbols[$];
    logic [BUF_W-1:0]   pend_bits = '0;
    logic [FILL_W-1:0]  pend_fill = '0;
    logic [POS_W-1:0]   emitted_count = '0;
    bit                 final_escaped = 1'b0;

    result_t            packed_results_due[$];
    result_t            due_result;
    int                 error_count = 0;
    int                 sender_idle_pct = 0;
    int                 sink_stall_pct = 0;

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            lut_code[i]    = '0;
            lut_len[i]     = '0;
            lut_written[i] = 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR at %0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Work out the results that one accepted request must produce.
    task automatic pack_code_bits(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                  input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0]   eff_len;
        logic [31:0]        acc;
        logic [BYTE_W-1:0]  grp;
        logic [GBITS_W-1:0] final_bits;
        int                 total;
        int                 n;
        result_t            res [3];
        n = 0;
        case (op)
            OP_LOAD:
            begin
                eff_len = (len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : len;
                lut_code[sym] = code & ~({CODE_W{1'b1}} << eff_len);
                lut_len[sym]  = eff_len;
                if (!lut_written[sym])
                    loaded_symbols = {loaded_symbols, sym};
                lut_written[sym] = 1'b1;
            end
            OP_ENCODE:
            begin
                acc   = ({25'b0, pend_bits} << lut_len[sym]) | 32'(lut_code[sym]);
                total = int'(pend_fill) + int'(lut_len[sym]);
                while (total >= 8)
                begin
                    grp = acc[total-8 +: 8];
                    total -= 8;
                    if (grp == ESCAPE_GROUP)
                    begin
                        res[n] = '{KIND_ESCAPE, 8'd0, emitted_count, 4'd8, 1'b0};
                        final_escaped = 1'b1;
                    end
                    else
                    begin
                        res[n] = '{KIND_DATA, grp, emitted_count, 4'd8, 1'b0};
                        emitted_count++;
                        final_escaped = 1'b0;
                    end
                    n++;
                end
                pend_bits = BUF_W'(acc & ((32'd1 << total) - 32'd1));
                pend_fill = FILL_W'(total);
            end
            OP_FLUSH:
            begin
                if (pend_fill != 0)
                begin
                    res[n] = '{KIND_DATA, BYTE_W'(pend_bits), emitted_count,
                               GBITS_W'(pend_fill), 1'b0};
                    n++;
                    emitted_count++;
                    final_bits = GBITS_W'(pend_fill);
                end
                else if (final_escaped)
                begin
                    final_bits = 4'd0;
                end
                else if (emitted_count != 0)
                begin
                    final_bits = 4'd8;
                end
                else
                begin
                    final_bits = 4'd0;
                end
                res[n] = '{KIND_TRAILER, 8'd0, emitted_count, final_bits, 1'b0};
                n++;
                pend_bits     = '0;
                pend_fill     = '0;
                emitted_count = '0;
                final_escaped = 1'b0;
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++)
        begin
            res[i].last = (i == n - 1);
            packed_results_due = {packed_results_due, res[i]};
        end
    endtask

    // Called right after a rising edge; returns at the edge that accepts the request,
    // leaving tvalid high so the next request can follow without a gap.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, len, code, sym};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pack_code_bits(op, sym, code, len);
    endtask

    // Output side: random back-pressure, and every accepted result checked in order.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (packed_results_due.size() == 0)
            begin
                report_mismatch("result with none expected", m_axis_tdata, 0);
            end
            else
            begin
                due_result = packed_results_due.pop_front();
                if (m_axis_tuser != due_result.kind)
                    report_mismatch("kind", m_axis_tuser, due_result.kind);
                if (m_axis_tdata[7:0] != due_result.byte_value)
                    report_mismatch("byte_value", m_axis_tdata[7:0], due_result.byte_value);
                if (m_axis_tdata[31:8] != due_result.position)
                    report_mismatch("position", m_axis_tdata[31:8], due_result.position);
                if (m_axis_tdata[35:32] != due_result.group_bits)
                    report_mismatch("group_bits", m_axis_tdata[35:32], due_result.group_bits);
                if (m_axis_tlast != due_result.last)
                    report_mismatch("last", m_axis_tlast, due_result.last);
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic test_directed_cases();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        send_request(OP_FLUSH, 8'h00, 24'h000000, 5'd0);     // empty stream
        send_request(OP_LOAD, 8'h00, 24'hFFFFFF, 5'd0);      // zero length clears the code
        send_request(OP_LOAD, 8'hFF, 24'hFFFFFF, 5'd24);
        send_request(OP_LOAD, 8'h01, 24'h5A5A5A, 5'd31);     // overlong length saturates
        send_request(OP_LOAD, 8'h02, 24'hFFFF1A, 5'd8);      // escape pattern
        send_request(OP_LOAD, 8'h03, 24'h000001, 5'd1);
        send_request(OP_LOAD, 8'h04, 24'hFFFFE5, 5'd3);
        send_request(OP_ENCODE, 8'h00, 24'hFFFFFF, 5'd31);   // nothing appended
        send_request(OP_ENCODE, 8'h02, 24'h000000, 5'd0);
        send_request(OP_FLUSH, 8'h00, 24'h000000, 5'd0);     // trailer after an escape
        send_request(OP_ENCODE, 8'hFF, 24'h000000, 5'd0);    // three full bytes
        send_request(OP_FLUSH, 8'hFF, 24'hFFFFFF, 5'd31);    // trailer after a full byte
        send_request(OP_ENCODE, 8'h03, 24'h000000, 5'd0);
        send_request(OP_ENCODE, 8'h01, 24'h000000, 5'd0);
        send_request(OP_ENCODE, 8'h04, 24'h000000, 5'd0);
        send_request(OP_UNUSED, 8'hFF, 24'hFFFFFF, 5'd31);   // ignored opcode
        send_request(OP_FLUSH, 8'h00, 24'h000000, 5'd0);     // partial group, then trailer
        send_request(OP_ENCODE, 8'h02, 24'h000000, 5'd0);
        send_request(OP_ENCODE, 8'h02, 24'h000000, 5'd0);
        send_request(OP_FLUSH, 8'h00, 24'h000000, 5'd0);
        send_request(OP_UNUSED, 8'h00, 24'h000000, 5'd0);
    endtask

    // Mostly encodes of loaded symbols, with table reloads, flushes and ignored requests.
    task automatic test_random_traffic(input int num_items, input int idle_pct,
                                       input int stall_pct);
        int                sent;
        int                pick;
        int                lsel;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        sent = 0;
        while (sent < num_items)
        begin
            pick = $urandom_range(0, 99);
            sym  = SYM_W'($urandom_range(0, 255));
            code = CODE_W'($urandom);
            len  = LEN_W'($urandom_range(0, 31));
            if (pick < 15)
            begin
                lsel = $urandom_range(0, 99);
                if (lsel < 6)
                begin
                    len = 5'd0;
                end
                else if (lsel < 12)
                begin
                    len = LEN_W'($urandom_range(25, 31));
                end
                else if (lsel < 25)
                begin
                    code = {16'($urandom_range(0, 65535)), ESCAPE_GROUP};
                    len  = 5'd8;
                end
                else
                begin
                    len = LEN_W'($urandom_range(1, 24));
                end
                send_request(OP_LOAD, sym, code, len);
                sent++;
            end
            else if (pick < 23)
            begin
                send_request(OP_FLUSH, sym, code, len);
                sent++;
            end
            else if (pick < 26)
            begin
                send_request(OP_UNUSED, sym, code, len);
            end
            else
            begin
                sym = loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)];
                send_request(OP_ENCODE, sym, code, len);
                sent++;
            end
        end
    endtask

    task automatic wait_for_drain();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (packed_results_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (packed_results_due.size() != 0)
            report_mismatch("expected results left over", packed_results_due.size(), 0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic(27, 0, 0);
        test_random_traffic(27, 56, 0);
        test_random_traffic(27, 0, 56);
        test_random_traffic(27, 32, 32);
        wait_for_drain();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
